// ===== src/stt_pkg.sv =====
// types, constants and helpers shared by the source text tokenizer
// no dependencies; imported by every tokenizer module
package stt_pkg;

  localparam int INT_VALUE_BITS = 31;
  localparam int MAX_RES        = 3;
  localparam int CNT_BITS       = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [INT_VALUE_BITS-1:0] INT_MAX = {INT_VALUE_BITS{1'b1}};

  // token kinds
  localparam logic [4:0] TK_EOF     = 5'd0;
  localparam logic [4:0] TK_ID      = 5'd1;
  localparam logic [4:0] TK_INT     = 5'd2;
  localparam logic [4:0] TK_STR     = 5'd3;
  localparam logic [4:0] TK_CHAR    = 5'd4;
  localparam logic [4:0] TK_ASSIGN  = 5'd5;
  localparam logic [4:0] TK_SEMI    = 5'd6;
  localparam logic [4:0] TK_LPAREN  = 5'd7;
  localparam logic [4:0] TK_RPAREN  = 5'd8;
  localparam logic [4:0] TK_LBRACE  = 5'd9;
  localparam logic [4:0] TK_RBRACE  = 5'd10;
  localparam logic [4:0] TK_LBRACK  = 5'd11;
  localparam logic [4:0] TK_RBRACK  = 5'd12;
  localparam logic [4:0] TK_COMMA   = 5'd13;
  localparam logic [4:0] TK_PLUS    = 5'd14;
  localparam logic [4:0] TK_MINUS   = 5'd15;
  localparam logic [4:0] TK_STAR    = 5'd16;
  localparam logic [4:0] TK_SLASH   = 5'd17;
  localparam logic [4:0] TK_CARET   = 5'd18;
  localparam logic [4:0] TK_PERCENT = 5'd19;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd1;
  localparam logic [2:0] ERR_EMPTY_CHAR = 3'd2;
  localparam logic [2:0] ERR_OPEN_CHAR  = 3'd3;
  localparam logic [2:0] ERR_OPEN_STR   = 3'd4;

  // special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [4:0]                token_kind;
    logic [7:0]                body_byte;
    logic                      has_byte;
    logic [INT_VALUE_BITS-1:0] int_value;
    logic                      token_start;
    logic                      token_end;
    logic [2:0]                error_code;
    logic                      last_result;
  } out_word_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CNT_BITS-1:0]           cnt;
    out_word_t [MAX_RES-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_letter(logic [7:0] b);
    return b inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] b);
    logic [4:0] k;
    case (b)
      8'h3d:   k = TK_ASSIGN;
      8'h3b:   k = TK_SEMI;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7b:   k = TK_LBRACE;
      8'h7d:   k = TK_RBRACE;
      8'h5b:   k = TK_LBRACK;
      8'h5d:   k = TK_RBRACK;
      8'h2c:   k = TK_COMMA;
      8'h2b:   k = TK_PLUS;
      8'h2d:   k = TK_MINUS;
      8'h2a:   k = TK_STAR;
      8'h2f:   k = TK_SLASH;
      8'h5e:   k = TK_CARET;
      8'h25:   k = TK_PERCENT;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic out_word_t mk_word(logic [4:0] kind, logic [7:0] b, logic hasb,
                                        logic [INT_VALUE_BITS-1:0] ival, logic st,
                                        logic en, logic [2:0] err);
    out_word_t w;
    w.token_kind  = kind;
    w.body_byte   = b;
    w.has_byte    = hasb;
    w.int_value   = ival;
    w.token_start = st;
    w.token_end   = en;
    w.error_code  = err;
    w.last_result = 1'b0;
    return w;
  endfunction

  function automatic bundle_t bundle_push(bundle_t bnd, out_word_t w);
    bundle_t r;
    r = bnd;
    if (r.cnt < CNT_BITS'(MAX_RES)) begin
      r.res[r.cnt[1:0]] = w;
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/source_text_tokenizer_unit.sv =====
// source text tokenizer top level
// depends on stt_pkg, stt_front, stt_queue and stt_back
// usage
//   in channel: one text byte per word (in_word.text_byte, in_word.final_byte),
//   taken at a clock edge where in_valid is high and in_stall is low
//   out channel: one token result per word, taken where out_valid is high and
//   out_stall is low; last_result flags the final result of each text byte
//   a text byte of zero, or final_byte, closes any open token and sends eof
//   after eof or an error result every further byte is taken and dropped
// timing
//   a byte with results is written, as it is taken, to the bundle queue between
//   scanner and output register, which then loads its results in order; one word
//   a cycle in while in_stall is low, one word a cycle out while out_stall is
//   low; a byte causing two or three results gives that many out words, and the
//   4-entry queue absorbs those bursts; in_stall rises only when it is full
// reset
//   rst_n is synchronous, active low: scanner returns to idle between tokens,
//   queue empties, out_valid drops, text accepted again
// stall: while out_stall is high the output word holds and the scanner keeps
//   taking bytes until the queue fills
module source_text_tokenizer_unit
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // queue status, shared by scanner (fullness) and output side (emptiness)
  qstat_t  qstat;
  logic    push;
  bundle_t push_bundle;
  logic    pop;
  bundle_t head;

  // stall only when no bundle slot is free
  assign in_stall = qstat.full;

  // scanner: byte classification and token state
  stt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .qstat       (qstat),
    .push        (push),
    .push_bundle (push_bundle)
  );

  // decouples scanning from output delivery
  stt_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .qstat       (qstat)
  );

  // serializes each bundle into single result words
  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

// ===== src/stt_front.sv =====
// front part: scan state and classification of each text byte
// depends on stt_pkg; builds the result bundle pushed into the queue
module stt_front
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_word,
  input  qstat_t   qstat,
  output logic     push,
  output bundle_t  push_bundle
);

  typedef enum logic [2:0] {
    M_IDLE, M_ID, M_NUM, M_STR, M_CHOPEN, M_CHHELD
  } mode_t;

  mode_t                     mode_r, mode_nxt;
  logic [INT_VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [7:0]                held_r, held_nxt;
  logic                      stop_r, stop_nxt;

  logic                      accept;
  logic [7:0]                b;
  logic                      fin;
  logic                      handled;
  logic                      end_fail;
  logic [INT_VALUE_BITS+3:0] prod;
  bundle_t                   bnd;

  assign accept = in_valid && !qstat.full;
  assign b      = in_word.text_byte;
  assign fin    = in_word.final_byte;

  // acc*10 + digit as shift-add, compared against the saturation limit
  assign prod = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
              + (INT_VALUE_BITS+4)'(b[3:0]);

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    held_nxt = held_r;
    stop_nxt = stop_r;
    handled  = 1'b0;
    end_fail = 1'b0;
    bnd      = '0;
    if (!stop_r) begin
      if (b != CH_NUL) begin
        // a non-continuing byte closes an open identifier or number first
        if (mode_nxt == M_ID && !is_letter(b)) begin
          bnd = bundle_push(bnd, mk_word(TK_ID, 8'd0, 1'b0, '0, 1'b0, 1'b1, ERR_NONE));
          mode_nxt = M_IDLE;
        end else if (mode_nxt == M_NUM && !is_digit(b)) begin
          bnd = bundle_push(bnd, mk_word(TK_INT, 8'd0, 1'b0, acc_nxt, 1'b1, 1'b1,
                                         ERR_NONE));
          acc_nxt  = '0;
          mode_nxt = M_IDLE;
        end
        handled = 1'b1;
        case (mode_nxt)
          M_ID: begin
            bnd = bundle_push(bnd, mk_word(TK_ID, b, 1'b1, '0, 1'b0, 1'b0, ERR_NONE));
          end
          M_NUM: begin
            if (prod > {4'd0, INT_MAX}) acc_nxt = INT_MAX;
            else acc_nxt = prod[INT_VALUE_BITS-1:0];
          end
          M_STR: begin
            if (b == CH_DQUOTE) begin
              bnd = bundle_push(bnd, mk_word(TK_STR, 8'd0, 1'b0, '0, 1'b0, 1'b1,
                                             ERR_NONE));
              mode_nxt = M_IDLE;
            end else begin
              bnd = bundle_push(bnd, mk_word(TK_STR, b, 1'b1, '0, 1'b0, 1'b0, ERR_NONE));
            end
          end
          M_CHOPEN: begin
            if (b == CH_SQUOTE) begin
              bnd = bundle_push(bnd, mk_word(TK_EOF, 8'd0, 1'b0, '0, 1'b0, 1'b0,
                                             ERR_EMPTY_CHAR));
              stop_nxt = 1'b1;
            end else begin
              held_nxt = b;
              mode_nxt = M_CHHELD;
            end
          end
          M_CHHELD: begin
            if (b == CH_SQUOTE) begin
              bnd = bundle_push(bnd, mk_word(TK_CHAR, held_nxt, 1'b1, '0, 1'b1, 1'b1,
                                             ERR_NONE));
              held_nxt = 8'd0;
              mode_nxt = M_IDLE;
            end else begin
              bnd = bundle_push(bnd, mk_word(TK_EOF, 8'd0, 1'b0, '0, 1'b0, 1'b0,
                                             ERR_OPEN_CHAR));
              stop_nxt = 1'b1;
            end
          end
          default: handled = 1'b0;
        endcase
        if (!handled) begin
          if (b == CH_SPACE || b == CH_NL) begin
            mode_nxt = M_IDLE;
          end else if (is_digit(b)) begin
            acc_nxt  = INT_VALUE_BITS'(b[3:0]);
            mode_nxt = M_NUM;
          end else if (is_letter(b)) begin
            bnd = bundle_push(bnd, mk_word(TK_ID, b, 1'b1, '0, 1'b1, 1'b0, ERR_NONE));
            mode_nxt = M_ID;
          end else if (b == CH_DQUOTE) begin
            bnd = bundle_push(bnd, mk_word(TK_STR, 8'd0, 1'b0, '0, 1'b1, 1'b0, ERR_NONE));
            mode_nxt = M_STR;
          end else if (b == CH_SQUOTE) begin
            mode_nxt = M_CHOPEN;
          end else if (op_kind(b) != TK_EOF) begin
            bnd = bundle_push(bnd, mk_word(op_kind(b), 8'd0, 1'b0, '0, 1'b1, 1'b1,
                                           ERR_NONE));
          end else begin
            bnd = bundle_push(bnd, mk_word(TK_EOF, 8'd0, 1'b0, '0, 1'b0, 1'b0,
                                           ERR_UNKNOWN));
            stop_nxt = 1'b1;
          end
        end
      end
      // end of text: close what is open, then eof
      if (!stop_nxt && (b == CH_NUL || fin)) begin
        case (mode_nxt)
          M_ID: begin
            if (bnd.cnt != '0) bnd.res[bnd.cnt[1:0] - 2'd1].token_end = 1'b1;
            else bnd = bundle_push(bnd, mk_word(TK_ID, 8'd0, 1'b0, '0, 1'b0, 1'b1,
                                                ERR_NONE));
          end
          M_NUM: begin
            bnd = bundle_push(bnd, mk_word(TK_INT, 8'd0, 1'b0, acc_nxt, 1'b1, 1'b1,
                                           ERR_NONE));
          end
          M_STR: begin
            bnd = bundle_push(bnd, mk_word(TK_EOF, 8'd0, 1'b0, '0, 1'b0, 1'b0,
                                           ERR_OPEN_STR));
            end_fail = 1'b1;
          end
          M_CHOPEN, M_CHHELD: begin
            bnd = bundle_push(bnd, mk_word(TK_EOF, 8'd0, 1'b0, '0, 1'b0, 1'b0,
                                           ERR_OPEN_CHAR));
            end_fail = 1'b1;
          end
          default: ;
        endcase
        if (!end_fail) begin
          bnd = bundle_push(bnd, mk_word(TK_EOF, 8'd0, 1'b0, '0, 1'b1, 1'b1, ERR_NONE));
          mode_nxt = M_IDLE;
          acc_nxt  = '0;
        end
        stop_nxt = 1'b1;
      end
      if (bnd.cnt != '0) bnd.res[bnd.cnt[1:0] - 2'd1].last_result = 1'b1;
    end
  end

  assign push        = accept && (bnd.cnt != '0);
  assign push_bundle = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r  <= '0;
      held_r <= 8'd0;
      stop_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      stop_r <= stop_nxt;
    end
  end

  // stopped text never produces results
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> !push) else $error("push after text stopped");

  // a pushed bundle always marks its final entry as last
  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_bundle.res[push_bundle.cnt[1:0] - 2'd1].last_result)
    else $error("bundle without last result");

endmodule

// ===== src/stt_queue.sv =====
// short bundle queue between the front and back parts
// depends on stt_pkg; one push and one pop per cycle
module stt_queue
  import stt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    pop,
  output bundle_t head,
  output qstat_t  qstat
);

  bundle_t              mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;

  assign qstat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !push) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.empty |-> !pop) else $error("pop from empty queue");

endmodule

// ===== src/stt_back.sv =====
// back part: walks the head bundle and feeds the output register
// depends on stt_pkg; pops a bundle after its last result is loaded
module stt_back
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   head,
  input  qstat_t    qstat,
  output logic      pop,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_word
);

  logic                out_valid_r;
  out_word_t           out_word_r;
  logic [CNT_BITS-1:0] sub_r;
  logic                load;
  logic                at_last;

  assign load    = !qstat.empty && (!out_valid_r || !out_stall);
  assign at_last = (sub_r == head.cnt - 1'b1);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= at_last ? '0 : sub_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word_r <= head.res[sub_r[1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !qstat.empty |-> (sub_r < head.cnt)) else $error("result index past bundle");

  a_sub_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (sub_r == '0)) else $error("result index not cleared after pop");

endmodule

// ===== bench/stt_token_checker.sv =====
// token checker for the source text tokenizer: follows the byte stream, predicts
// the token words it causes and compares them with the out channel
// depends on stt_pkg only
module stt_token_checker
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        mismatches,
  output int        pending
);

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_QUOTE, SCAN_QUOTED
  } scan_t;

  scan_t                     mode;
  logic [INT_VALUE_BITS-1:0] acc;
  logic [7:0]                held;
  logic                      halted;

  out_word_t burst [MAX_RES];
  int        burst_len;
  out_word_t expected_tokens [$];
  out_word_t want;

  function automatic logic letter_byte(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic digit_byte(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // position in the mark list gives the kind, TK_EOF when not a mark
  function automatic logic [4:0] punct_kind(logic [7:0] b);
    string marks;
    marks = "=;(){}[],+-*/^%";
    for (int i = 0; i < marks.len(); i++)
      if (marks[i] == b) return TK_ASSIGN + 5'(i);
    return TK_EOF;
  endfunction

  task automatic add_token(input logic [4:0] kind, input logic [7:0] b, input logic hasb,
                           input logic [INT_VALUE_BITS-1:0] ival, input logic st,
                           input logic en, input logic [2:0] err);
    if (burst_len < MAX_RES) begin
      burst[burst_len] = '{token_kind: kind, body_byte: b, has_byte: hasb, int_value: ival,
                           token_start: st, token_end: en, error_code: err,
                           last_result: 1'b0};
      burst_len++;
    end
  endtask

  task automatic raise_error(input logic [2:0] err);
    add_token(TK_EOF, 8'h00, 1'b0, '0, 1'b0, 1'b0, err);
    halted = 1'b1;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic [4:0]      k;
    longint unsigned d, cur, lim;
    // a byte that cannot continue an open identifier or number closes it first
    if (mode == SCAN_IDENT && !letter_byte(b)) begin
      add_token(TK_ID, 8'h00, 1'b0, '0, 1'b0, 1'b1, ERR_NONE);
      mode = SCAN_IDLE;
    end else if (mode == SCAN_NUMBER && !digit_byte(b)) begin
      add_token(TK_INT, 8'h00, 1'b0, acc, 1'b1, 1'b1, ERR_NONE);
      acc  = '0;
      mode = SCAN_IDLE;
    end
    case (mode)
      SCAN_IDENT: add_token(TK_ID, b, 1'b1, '0, 1'b0, 1'b0, ERR_NONE);
      SCAN_NUMBER: begin
        d   = 64'(b) - 64'd48;
        cur = 64'(acc);
        lim = 64'(INT_MAX);
        if (cur > (lim - d) / 10) acc = INT_MAX;
        else acc = INT_VALUE_BITS'(cur * 10 + d);
      end
      SCAN_STRING: begin
        if (b == CH_DQUOTE) begin
          add_token(TK_STR, 8'h00, 1'b0, '0, 1'b0, 1'b1, ERR_NONE);
          mode = SCAN_IDLE;
        end else begin
          add_token(TK_STR, b, 1'b1, '0, 1'b0, 1'b0, ERR_NONE);
        end
      end
      SCAN_QUOTE: begin
        if (b == CH_SQUOTE) begin
          raise_error(ERR_EMPTY_CHAR);
        end else begin
          held = b;
          mode = SCAN_QUOTED;
        end
      end
      SCAN_QUOTED: begin
        if (b == CH_SQUOTE) begin
          add_token(TK_CHAR, held, 1'b1, '0, 1'b1, 1'b1, ERR_NONE);
          held = 8'h00;
          mode = SCAN_IDLE;
        end else begin
          raise_error(ERR_OPEN_CHAR);
        end
      end
      default: begin
        k = punct_kind(b);
        if (digit_byte(b)) begin
          acc  = INT_VALUE_BITS'(b - 8'h30);
          mode = SCAN_NUMBER;
        end else if (letter_byte(b)) begin
          add_token(TK_ID, b, 1'b1, '0, 1'b1, 1'b0, ERR_NONE);
          mode = SCAN_IDENT;
        end else if (b == CH_DQUOTE) begin
          add_token(TK_STR, 8'h00, 1'b0, '0, 1'b1, 1'b0, ERR_NONE);
          mode = SCAN_STRING;
        end else if (b == CH_SQUOTE) begin
          mode = SCAN_QUOTE;
        end else if (k != TK_EOF) begin
          add_token(k, 8'h00, 1'b0, '0, 1'b1, 1'b1, ERR_NONE);
        end else if (b != CH_SPACE && b != CH_NL) begin
          raise_error(ERR_UNKNOWN);
        end
      end
    endcase
  endtask

  // end of text: flush the open token, then eof unless the text was left open
  task automatic close_text();
    case (mode)
      SCAN_IDENT: begin
        if (burst_len > 0) burst[burst_len-1].token_end = 1'b1;
        else add_token(TK_ID, 8'h00, 1'b0, '0, 1'b0, 1'b1, ERR_NONE);
      end
      SCAN_NUMBER: add_token(TK_INT, 8'h00, 1'b0, acc, 1'b1, 1'b1, ERR_NONE);
      SCAN_STRING: raise_error(ERR_OPEN_STR);
      SCAN_QUOTE, SCAN_QUOTED: raise_error(ERR_OPEN_CHAR);
      default: ;
    endcase
    if (!halted) begin
      add_token(TK_EOF, 8'h00, 1'b0, '0, 1'b1, 1'b1, ERR_NONE);
      mode   = SCAN_IDLE;
      acc    = '0;
      halted = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode       = SCAN_IDLE;
      acc        = '0;
      held       = 8'h00;
      halted     = 1'b0;
      mismatches = 0;
      expected_tokens.delete();
    end else begin
      // results of a word taken at this edge show up later, so check first
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token word %h", out_word);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_word.token_kind != want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind,
                   out_word.token_kind);
            mismatches++;
          end
          if (out_word.body_byte != want.body_byte) begin
            $error("body_byte: expected %h, got %h", want.body_byte, out_word.body_byte);
            mismatches++;
          end
          if (out_word.has_byte != want.has_byte) begin
            $error("has_byte: expected %0d, got %0d", want.has_byte, out_word.has_byte);
            mismatches++;
          end
          if (out_word.int_value != want.int_value) begin
            $error("int_value: expected %0d, got %0d", want.int_value, out_word.int_value);
            mismatches++;
          end
          if (out_word.token_start != want.token_start) begin
            $error("token_start: expected %0d, got %0d", want.token_start,
                   out_word.token_start);
            mismatches++;
          end
          if (out_word.token_end != want.token_end) begin
            $error("token_end: expected %0d, got %0d", want.token_end, out_word.token_end);
            mismatches++;
          end
          if (out_word.error_code != want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code,
                   out_word.error_code);
            mismatches++;
          end
          if (out_word.last_result != want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result,
                   out_word.last_result);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall && !halted) begin
        burst_len = 0;
        if (in_word.text_byte != CH_NUL) scan_byte(in_word.text_byte);
        if (!halted && (in_word.text_byte == CH_NUL || in_word.final_byte)) close_text();
        if (burst_len > 0) burst[burst_len-1].last_result = 1'b1;
        for (int i = 0; i < burst_len; i++) expected_tokens.push_back(burst[i]);
      end
    end
    pending = expected_tokens.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the source text tokenizer: clock, reset, text stimulus and verdict
// depends on stt_pkg, source_text_tokenizer_unit and stt_token_checker
module tb_top;
  import stt_pkg::*;

  localparam int RANDOM_END   = 300;     // words taken before the text is closed
  localparam int HOLD_AT      = 120;     // out side holds off once past this word
  localparam int HOLD_CYCLES  = 90;
  localparam int CALM_FROM    = 200;     // no idling on either side in this window
  localparam int CALM_TO      = 260;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int   mismatches;
  int   pending;
  int   sent_cnt;
  int   cycle_cnt;
  logic calm;

  string puncts  = "=;(){}[],+-*/^%";
  string strays  = "!#$&.:<>?@\\_`|~";   // printable bytes outside the token set

  assign calm = sent_cnt >= CALM_FROM && sent_cnt < CALM_TO;

  source_text_tokenizer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  stt_token_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block locks up
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[source_text_tokenizer_unit] ERROR");
      $finish;
    end
  end

  // one text byte per word; random idle gaps carry junk payload with valid low
  task automatic feed_byte(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      in_word  <= '{text_byte: 8'($urandom), final_byte: 1'($urandom)};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{text_byte: b, final_byte: fin};
    // payload stays put until the block takes it
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_cnt++;
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'h61 + 8'($urandom_range(25)) : 8'h41 + 8'($urandom_range(25));
  endfunction

  // any nonzero byte except the one that would close the literal
  function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1)); while (b == avoid);
    return b;
  endfunction

  // out side: random stalls, one long hold-off so the queue fills and in_stall rises
  initial begin
    logic held_once;
    held_once = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && sent_cnt >= HOLD_AT) begin
        held_once = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !calm && $urandom_range(99) < 27;
    end
  end

  initial begin
    int n;
    int pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    sent_cnt = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: identifier closed by a mark, all fifteen marks, newline skip,
    // a single digit number, string markers around the top and bottom bytes,
    // and a char literal
    feed_text("zA=;(){}[],+-*/^%\n0");
    feed_byte(CH_DQUOTE, 1'b0);
    feed_byte(8'hff, 1'b0);
    feed_byte(8'h01, 1'b0);
    feed_byte(CH_DQUOTE, 1'b0);
    feed_text("'~'");

    // random well-formed tokens, sometimes glued together, sometimes spaced
    while (sent_cnt < RANDOM_END) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        n = $urandom_range(6, 1);
        repeat (n) feed_byte(rand_letter(), 1'b0);
      end else if (pick < 40) begin
        // mostly short numbers, now and then long enough to saturate
        n = ($urandom_range(3) == 0) ? $urandom_range(12, 9) : $urandom_range(4, 1);
        repeat (n) feed_byte(8'h30 + 8'($urandom_range(9)), 1'b0);
      end else if (pick < 43) begin
        // right at the saturation point
        feed_text(pick == 40 ? "2147483647" : pick == 41 ? "2147483648" : "214748364");
      end else if (pick < 58) begin
        feed_byte(CH_DQUOTE, 1'b0);
        n = $urandom_range(5, 0);
        repeat (n) feed_byte(byte_other_than(CH_DQUOTE), 1'b0);
        feed_byte(CH_DQUOTE, 1'b0);
      end else if (pick < 68) begin
        feed_byte(CH_SQUOTE, 1'b0);
        feed_byte(byte_other_than(CH_SQUOTE), 1'b0);
        feed_byte(CH_SQUOTE, 1'b0);
      end else if (pick < 88) begin
        feed_byte(puncts[$urandom_range(14)], 1'b0);
      end else begin
        feed_byte($urandom_range(1) ? CH_SPACE : CH_NL, 1'b0);
      end
      if ($urandom_range(1)) feed_byte($urandom_range(1) ? CH_SPACE : CH_NL, 1'b0);
    end

    // the text ends once per run: pick how
    case ($urandom_range(6))
      0: feed_byte(CH_NUL, 1'($urandom));                  // nul closes the text
      1: begin                                             // identifier on the last byte
        feed_byte(rand_letter(), 1'b0);
        feed_byte(rand_letter(), 1'b1);
      end
      2: begin                                             // number, mark and eof at once
        feed_text(" 42");
        feed_byte(8'h3b, 1'b1);
      end
      3: feed_byte($urandom_range(1) ? 8'($urandom_range(255, 128))
                                     : strays[$urandom_range(strays.len() - 1)],
                   1'($urandom));                          // unknown byte
      4: begin                                             // empty char literal
        feed_byte(CH_SQUOTE, 1'b0);
        feed_byte(CH_SQUOTE, 1'($urandom));
      end
      5: begin                                             // unclosed char literal
        feed_byte(CH_SQUOTE, 1'b0);
        feed_byte(byte_other_than(CH_SQUOTE), 1'($urandom));
        feed_byte(8'h78, 1'b0);
      end
      default: begin                                       // unterminated string
        feed_byte(CH_DQUOTE, 1'b0);
        feed_byte(byte_other_than(CH_DQUOTE), 1'b0);
        if ($urandom_range(1)) feed_byte(CH_NUL, 1'($urandom));
        else feed_byte(8'h41, 1'b1);
      end
    endcase

    // text is stopped now: these words must be taken and dropped
    repeat (12) feed_byte(8'($urandom), 1'($urandom));
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[source_text_tokenizer_unit] OK");
    end else begin
      $display("[source_text_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule
